### hw/rtl/vcp_pkg.sv
package vcp_pkg;

  // Field widths
  localparam int COORD_W     = 16;
  localparam int VALUE_W     = 8;
  localparam int SEL_W       = 8;
  localparam int COUNT_W     = 16;
  localparam int SUM_W       = 24;
  localparam int PIX_VALUE_W = 8;
  localparam int ALPHA_W     = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // Commands
  localparam logic CMD_ACCUMULATE = 1'b0;
  localparam logic CMD_READ       = 1'b1;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_ROW = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ROW = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_COL = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_COL = 2'd3;

  localparam logic signed [COORD_W-1:0] MIN_INDEX_RESET = 16'sd0;
  localparam logic signed [COORD_W-1:0] MAX_INDEX_RESET = 16'sd255;

  // Classification constants
  localparam logic [SUM_W-1:0]       BRIGHT_MULT  = 24'd116;
  localparam logic [COUNT_W-1:0]     SPARSE_LIMIT = 16'd5;
  localparam logic [PIX_VALUE_W-1:0] PIX_DARK     = 8'd0;
  localparam logic [PIX_VALUE_W-1:0] PIX_SPARSE   = 8'd100;
  localparam logic [PIX_VALUE_W-1:0] PIX_BRIGHT   = 8'd255;
  localparam logic [ALPHA_W-1:0]     ALPHA_NONE   = 7'd0;
  localparam logic [ALPHA_W-1:0]     ALPHA_SET    = 7'd90;

  // Result queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = OUT_PTR_W + 1;

  typedef struct packed {
    logic signed [COORD_W-1:0] min_row;
    logic signed [COORD_W-1:0] max_row;
    logic signed [COORD_W-1:0] min_col;
    logic signed [COORD_W-1:0] max_col;
  } box_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [SUM_W-1:0]   sum;
  } pixel_t;

  typedef struct packed {
    logic [PIX_VALUE_W-1:0] value;
    logic [ALPHA_W-1:0]     alpha;
  } result_t;

  // Control of an item between address stage and update stage.
  typedef struct packed {
    logic               valid;
    logic               command;
    logic               hit;
    logic [VALUE_W-1:0] value;
  } stage_item_t;

endpackage

### hw/rtl/vcp_in_if.sv
interface vcp_in_if;
  import vcp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [COORD_W-1:0] voxel_x;
  logic signed [COORD_W-1:0] voxel_y;
  logic [VALUE_W-1:0]        voxel_value;
  logic [SEL_W-1:0]          read_row;
  logic [SEL_W-1:0]          read_col;

  modport source (
    output valid, command, voxel_x, voxel_y, voxel_value, read_row, read_col,
    input  ready
  );

  modport sink (
    input  valid, command, voxel_x, voxel_y, voxel_value, read_row, read_col,
    output ready
  );

endinterface

### hw/rtl/vcp_out_if.sv
interface vcp_out_if;
  import vcp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [PIX_VALUE_W-1:0] pixel_value;
  logic [ALPHA_W-1:0]     pixel_alpha;

  modport source (
    output valid, pixel_value, pixel_alpha,
    input  ready
  );

  modport sink (
    input  valid, pixel_value, pixel_alpha,
    output ready
  );

endinterface

### hw/rtl/vcp_ram.sv
module vcp_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/vcp_front.sv
module vcp_front #(
  parameter int GRID_ROWS = 256,
  parameter int GRID_COLS = 256,
  parameter int AW = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               take,
  input  logic                               command,
  input  logic signed [vcp_pkg::COORD_W-1:0] voxel_x,
  input  logic signed [vcp_pkg::COORD_W-1:0] voxel_y,
  input  logic [vcp_pkg::VALUE_W-1:0]        voxel_value,
  input  logic [vcp_pkg::SEL_W-1:0]          read_row,
  input  logic [vcp_pkg::SEL_W-1:0]          read_col,
  input  vcp_pkg::box_t                      box,
  output logic                               busy,
  output logic [AW-1:0]                      rd_addr,
  output vcp_pkg::stage_item_t               item,
  output logic [AW-1:0]                      item_addr
);
  import vcp_pkg::*;

  localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam logic [COORD_W-1:0] ROW_LIMIT = COORD_W'(GRID_ROWS);
  localparam logic [COORD_W-1:0] COL_LIMIT = COORD_W'(GRID_COLS);

  // Decode stage registers
  logic               a_valid;
  logic               a_command;
  logic               a_box;
  logic [COORD_W-1:0] a_row;
  logic [COORD_W-1:0] a_col;
  logic [VALUE_W-1:0] a_value;

  logic               in_box;
  logic [COORD_W-1:0] acc_row;
  logic [COORD_W-1:0] acc_col;
  logic               grid_ok;
  logic [RW-1:0]      row_idx;
  logic [CW-1:0]      col_idx;

  always_comb begin
    in_box  = (voxel_x >= box.min_row) && (voxel_x <= box.max_row) &&
              (voxel_y >= box.min_col) && (voxel_y <= box.max_col);
    // Inside the box the difference is never negative.
    acc_row = box.max_row - voxel_x;
    acc_col = box.max_col - voxel_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= take;
    end
    if (take) begin
      a_command <= command;
      a_value   <= voxel_value;
      if (command == CMD_READ) begin
        a_row <= COORD_W'(read_row);
        a_col <= COORD_W'(read_col);
        a_box <= 1'b1;
      end else begin
        a_row <= acc_row;
        a_col <= acc_col;
        a_box <= in_box;
      end
    end
  end

  always_comb begin
    grid_ok = (a_row < ROW_LIMIT) && (a_col < COL_LIMIT);
    row_idx = a_row[RW-1:0];
    col_idx = a_col[CW-1:0];
    rd_addr = AW'(row_idx) * AW'(GRID_COLS) + AW'(col_idx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= a_valid;
    end
    item.command <= a_command;
    item.hit     <= a_box && grid_ok;
    item.value   <= a_value;
    item_addr    <= rd_addr;
  end

  assign busy = a_valid;

endmodule

### hw/rtl/vcp_update.sv
module vcp_update #(
  parameter int AW = 16,
  parameter int MAX_COUNT = 65535
) (
  input  logic                 clk,
  input  logic                 rst,
  input  vcp_pkg::stage_item_t item,
  input  logic [AW-1:0]        item_addr,
  input  vcp_pkg::pixel_t      ram_q,
  output logic                 wr_en,
  output logic [AW-1:0]        wr_addr,
  output vcp_pkg::pixel_t      wr_data,
  output logic                 push,
  output vcp_pkg::result_t     push_data
);
  import vcp_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_COUNT);

  logic          fwd_valid;
  logic [AW-1:0] fwd_addr;
  pixel_t        fwd_data;

  pixel_t           cur;
  logic [SUM_W-1:0] bright_floor;

  // The entry written last cycle was read from memory before the write landed.
  always_comb begin
    cur          = (fwd_valid && (fwd_addr == item_addr)) ? fwd_data : ram_q;
    bright_floor = SUM_W'(cur.count) * BRIGHT_MULT;
  end

  always_comb begin
    push_data.value = PIX_DARK;
    push_data.alpha = ALPHA_NONE;
    if (item.hit && (cur.count != '0)) begin
      push_data.alpha = ALPHA_SET;
      priority if (cur.sum >= bright_floor) begin
        push_data.value = PIX_BRIGHT;
      end else if (cur.count > SPARSE_LIMIT) begin
        push_data.value = PIX_DARK;
      end else begin
        push_data.value = PIX_SPARSE;
      end
    end
  end

  always_comb begin
    push    = item.valid && (item.command == CMD_READ);
    wr_addr = item_addr;
    wr_en   = 1'b0;
    wr_data = '0;
    if (item.valid && item.hit) begin
      if (item.command == CMD_READ) begin
        wr_en = 1'b1;
      end else if (cur.count < COUNT_LIMIT) begin
        wr_en         = 1'b1;
        wr_data.count = cur.count + COUNT_W'(1);
        wr_data.sum   = cur.sum + SUM_W'(item.value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= wr_en;
    end
    fwd_addr <= wr_addr;
    fwd_data <= wr_data;
  end

endmodule

### hw/rtl/vcp_out_fifo.sv
module vcp_out_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  input  vcp_pkg::result_t                 push_data,
  input  logic                             pop,
  output logic                             valid,
  output vcp_pkg::result_t                 head,
  output logic [vcp_pkg::OUT_CNT_W-1:0]    count
);
  import vcp_pkg::*;

  result_t              mem [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

endmodule

### hw/rtl/voxel_column_projection_classifier_top.sv
// Voxel column projection classifier.
// Items arrive on in_ch (valid/ready). An accumulate item adds a voxel to the
// pixel at row max_row_index - voxel_x, column max_col_index - voxel_y, if it
// lies inside the configured box and the grid; it gives no result. A read item
// returns one classified item on out_ch and clears the pixel.
// Pixel counts and sums live in one synchronous RAM, updated by a
// read-modify-write pipeline with forwarding of the last write, so an item can
// be accepted every cycle while in_ch ready is high. A read result passes the
// decode stage at acceptance, then the RAM read, then the update into the result
// queue, from which it is shown on out_ch.
// A four-entry result queue absorbs a stalled receiver; in_ch ready drops once
// the items in flight plus queued results reach the queue depth.
// After reset the RAM is swept clear, one entry per cycle, with in_ch ready
// low during the sweep. Box registers are written through cfg_write/cfg_index/
// cfg_data; the user must write them only while idle; this is not enforced.
module voxel_column_projection_classifier_top #(
  parameter int GRID_ROWS = 256,
  parameter int GRID_COLS = 256,
  parameter int MAX_COUNT = 65535
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [vcp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [vcp_pkg::CFG_DATA_W-1:0]     cfg_data,
  vcp_in_if.sink                             in_ch,
  vcp_out_if.source                          out_ch
);
  import vcp_pkg::*;

  localparam int DEPTH = GRID_ROWS * GRID_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

  box_t            box;
  logic            clearing;
  logic [AW-1:0]   clr_addr;
  logic            take;
  logic            front_busy;
  logic [AW-1:0]   rd_addr;
  stage_item_t     item;
  logic [AW-1:0]   item_addr;
  pixel_t          ram_q;
  logic            upd_we;
  logic [AW-1:0]   upd_addr;
  pixel_t          upd_data;
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  pixel_t          ram_wdata;
  logic            push;
  result_t         push_data;
  result_t         head;
  logic [OUT_CNT_W-1:0] fifo_count;
  logic [OUT_CNT_W-1:0] occupancy;

  always_ff @(posedge clk) begin
    if (rst) begin
      box.min_row <= MIN_INDEX_RESET;
      box.max_row <= MAX_INDEX_RESET;
      box.min_col <= MIN_INDEX_RESET;
      box.max_col <= MAX_INDEX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_ROW: box.min_row <= cfg_data;
        REG_MAX_ROW: box.max_row <= cfg_data;
        REG_MIN_COL: box.min_col <= cfg_data;
        REG_MAX_COL: box.max_col <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + AW'(1);
      end
    end
  end

  always_comb begin
    occupancy   = OUT_CNT_W'(front_busy) + OUT_CNT_W'(item.valid) + fifo_count;
    in_ch.ready = !clearing && (occupancy < OUT_CNT_W'(OUT_DEPTH));
    take        = in_ch.valid && in_ch.ready;
    ram_we      = clearing || upd_we;
    ram_waddr   = clearing ? clr_addr : upd_addr;
    ram_wdata   = clearing ? '0 : upd_data;
  end

  vcp_front #(
    .GRID_ROWS(GRID_ROWS),
    .GRID_COLS(GRID_COLS),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .take(take),
    .command(in_ch.command),
    .voxel_x(in_ch.voxel_x),
    .voxel_y(in_ch.voxel_y),
    .voxel_value(in_ch.voxel_value),
    .read_row(in_ch.read_row),
    .read_col(in_ch.read_col),
    .box(box),
    .busy(front_busy),
    .rd_addr(rd_addr),
    .item(item),
    .item_addr(item_addr)
  );

  vcp_ram #(
    .WIDTH($bits(pixel_t)),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  vcp_update #(
    .AW(AW),
    .MAX_COUNT(MAX_COUNT)
  ) u_update (
    .clk(clk),
    .rst(rst),
    .item(item),
    .item_addr(item_addr),
    .ram_q(ram_q),
    .wr_en(upd_we),
    .wr_addr(upd_addr),
    .wr_data(upd_data),
    .push(push),
    .push_data(push_data)
  );

  vcp_out_fifo u_out_fifo (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .pop(out_ch.valid && out_ch.ready),
    .valid(out_ch.valid),
    .head(head),
    .count(fifo_count)
  );

  assign out_ch.pixel_value = head.value;
  assign out_ch.pixel_alpha = head.alpha;

endmodule

### hw/rtl/vcp_checker.sv
module vcp_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [vcp_pkg::PIX_VALUE_W-1:0] pixel_value,
  input logic [vcp_pkg::ALPHA_W-1:0]     pixel_alpha
);
  import vcp_pkg::*;

  // The store is swept after reset, so no item is taken right after it.
  a_no_take_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("in_ch ready high right after reset");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(pixel_value) && $stable(pixel_alpha))
    else $error("result changed while stalled");

  // An empty pixel reads 0/0; any other gives alpha 90 and one of three values.
  a_result_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((pixel_alpha == ALPHA_NONE) && (pixel_value == PIX_DARK)) ||
                  ((pixel_alpha == ALPHA_SET) &&
                   ((pixel_value == PIX_DARK) || (pixel_value == PIX_SPARSE) ||
                    (pixel_value == PIX_BRIGHT))))
    else $error("illegal pixel classification");

endmodule

bind voxel_column_projection_classifier_top vcp_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .pixel_value(out_ch.pixel_value),
  .pixel_alpha(out_ch.pixel_alpha)
);
